@@ sv/time_minimal_velocity_profile_assert.svh @@
// Assertion macros for the velocity profile block.
`ifndef TIME_MINIMAL_VELOCITY_PROFILE_ASSERT_SVH
`define TIME_MINIMAL_VELOCITY_PROFILE_ASSERT_SVH

// Checked at every clock edge outside reset.
`define TMVP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tmvp assertion failed");

// Checked at every clock edge, reset included.
`define TMVP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tmvp reset assertion failed");

`endif

@@ sv/tmvp_pkg.sv @@
`timescale 1ns / 1ps
package tmvp_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int LIMIT_W    = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL_LIMIT = 1'b0,
    REG_SPEED_LIMIT = 1'b1
  } cfg_reg_e;

  // integer square root of the 64-bit energy term, one root bit per cell
  localparam int SQ_IN_W   = 64;
  localparam int SQ_ROOT_W = 32;
  localparam int SQ_REM_W  = 34;

  // quotient bits of the time dividers and of the integer divider
  localparam int TIME_Q_W = 40;
  localparam int IDIV_Q_W = 63;

  typedef struct packed {
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
    logic [SQ_IN_W-1:0]   rad;
  } sqrt_st_t;

endpackage

@@ sv/time_minimal_velocity_profile.sv @@
`timescale 1ns / 1ps
// Time-minimal trapezoidal velocity profile for one axis. One item enters per clock while
// the pipeline is enabled; throughput is one item per cycle while results are taken. The
// depth is set by the 63-cell integer divider chain (start-speed term of the cruise
// time) followed by the 40-cell fixed-point divider chains for the phase times; the
// square root runs as a 32-cell chain beside the first divider. The whole pipeline
// advances together and keeps filling while a finished result waits at the output
// register, until a valid item reaches the last stage. Limits are read live from the
// configuration registers and must only be written while no item is in flight.
module time_minimal_velocity_profile #(
  parameter int FRAC_BITS = tmvp_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tmvp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tmvp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [31:0]               start_position_i,
  input  logic signed [31:0]               start_speed_i,
  input  logic signed [31:0]               goal_position_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [30:0]                      peak_speed_o,
  output logic signed [31:0]               signed_accel_o,
  output logic [31:0]                      accel_end_time_o,
  output logic [31:0]                      decel_start_time_o,
  output logic [31:0]                      final_time_o,
  output logic                             is_triangular_o,
  output logic                             saturated_o
);

  import tmvp_pkg::*;

  localparam int NST       = 3 + IDIV_Q_W + 1 + TIME_Q_W + 1;
  localparam int TNUM_W    = 64 + FRAC_BITS;
  localparam int CAP_W     = TIME_Q_W + 1;
  localparam int SIDE1_W   = 35;
  localparam int SIDE2_W   = LIMIT_W + 2 + CAP_W;
  localparam logic [LIMIT_W-1:0] ACCEL_RST = LIMIT_W'(2 << FRAC_BITS);
  localparam logic [LIMIT_W-1:0] SPEED_RST = LIMIT_W'(1 << FRAC_BITS);

  function automatic logic [CAP_W-1:0] cap_q(input logic ovf, input logic [TIME_Q_W-1:0] q);
    cap_q = ovf ? {1'b1, {TIME_Q_W{1'b0}}} : {1'b0, q};
  endfunction

  // configuration
  logic [LIMIT_W-1:0] accel_q;
  logic [LIMIT_W-1:0] speed_q;
  logic [LIMIT_W-1:0] a_eff;
  logic [LIMIT_W-1:0] wmax_eff;
  logic [61:0]        wmax2_q;

  assign cfg_ready_o = 1'b1;
  assign a_eff    = (accel_q == '0) ? LIMIT_W'(1) : accel_q;
  assign wmax_eff = (speed_q == '0) ? LIMIT_W'(1) : speed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q <= ACCEL_RST;
      speed_q <= SPEED_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ACCEL_LIMIT: accel_q <= cfg_data_i[LIMIT_W-1:0];
        REG_SPEED_LIMIT: speed_q <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    wmax2_q <= wmax_eff * wmax_eff;
  end

  // pipeline control
  logic [NST-1:0] vld_q;
  logic           out_valid_q;
  logic           en;

  assign en         = !vld_q[NST-1] || !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        vld_q <= {vld_q[NST-2:0], in_valid_i};
      end
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (en && vld_q[NST-1]) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // stage 1: direction
  logic signed [32:0] delta_n;
  logic signed [32:0] w0x;
  logic signed [32:0] ws_n;
  logic               neg1_q;
  logic [32:0]        ad1_q;
  logic signed [32:0] ws1_q;
  logic [31:0]        aw1_q;

  assign delta_n = $signed({goal_position_i[31], goal_position_i})
                 - $signed({start_position_i[31], start_position_i});
  assign w0x  = $signed({start_speed_i[31], start_speed_i});
  assign ws_n = delta_n[32] ? -w0x : w0x;

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg1_q <= delta_n[32];
      ad1_q  <= delta_n[32] ? 33'(-delta_n) : 33'(delta_n);
      ws1_q  <= ws_n;
      aw1_q  <= ws_n[32] ? 32'(-ws_n) : ws_n[31:0];
    end
  end

  // stage 2: products
  logic [63:0]        w0sq2_q;
  logic [63:0]        prod2_q;
  logic               neg2_q;
  logic [32:0]        ad2_q;
  logic signed [32:0] ws2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      w0sq2_q <= aw1_q * aw1_q;
      prod2_q <= a_eff * ad1_q;
      neg2_q  <= neg1_q;
      ad2_q   <= ad1_q;
      ws2_q   <= ws1_q;
    end
  end

  // stage 3: energy term and profile choice
  logic [63:0]        s_n;
  logic [63:0]        s3_q;
  logic               tri3_q;
  logic [63:0]        w0sq3_q;
  logic               neg3_q;
  logic [32:0]        ad3_q;
  logic signed [32:0] ws3_q;

  assign s_n = {1'b0, w0sq2_q[63:1]} + prod2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q    <= s_n;
      tri3_q  <= s_n < {2'b00, wmax2_q};
      w0sq3_q <= w0sq2_q;
      neg3_q  <= neg2_q;
      ad3_q   <= ad2_q;
      ws3_q   <= ws2_q;
    end
  end

  // first chain group
  logic [SQ_ROOT_W-1:0] root_c;
  logic [SQ_ROOT_W-1:0] root_m;
  logic [IDIV_Q_W-1:0]  iq_m;
  logic [TIME_Q_W-1:0]  d3_q;
  logic                 d3_ovf;
  logic [CAP_W-1:0]     d3_m;
  logic [SIDE1_W-1:0]   side1_m;

  tmvp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s3_q),
    .root_o (root_c)
  );

  tmvp_delay #(.WIDTH(SQ_ROOT_W), .LEN(IDIV_Q_W - SQ_ROOT_W)) u_root_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (root_c),
    .d_o   (root_m)
  );

  tmvp_div #(.NUM_W(64), .DEN_W(32), .Q_W(IDIV_Q_W)) u_idiv (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (w0sq3_q),
    .den_i ({wmax_eff, 1'b0}),
    .quo_o (iq_m),
    .ovf_o ()
  );

  tmvp_div #(.NUM_W(TNUM_W), .DEN_W(LIMIT_W), .Q_W(TIME_Q_W)) u_div_cruise (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({31'd0, ad3_q, {FRAC_BITS{1'b0}}}),
    .den_i (wmax_eff),
    .quo_o (d3_q),
    .ovf_o (d3_ovf)
  );

  tmvp_delay #(.WIDTH(CAP_W), .LEN(IDIV_Q_W - TIME_Q_W)) u_cruise_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (cap_q(d3_ovf, d3_q)),
    .d_o   (d3_m)
  );

  tmvp_delay #(.WIDTH(SIDE1_W), .LEN(IDIV_Q_W)) u_side1_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({neg3_q, tri3_q, ws3_q}),
    .d_o   (side1_m)
  );

  // mid stage: numerators
  logic               neg_m;
  logic               tri_m;
  logic [32:0]        ws_mu;
  logic [LIMIT_W-1:0] wm_m;
  logic signed [65:0] wm66;
  logic signed [65:0] ws66;
  logic signed [65:0] iq66;
  logic signed [65:0] x1;
  logic signed [65:0] x2;
  logic [63:0]        n1_q;
  logic [63:0]        n2_q;
  logic [63:0]        n4_q;
  logic [SIDE2_W-1:0] side2_q;

  assign {neg_m, tri_m, ws_mu} = side1_m;
  assign wm_m = tri_m ? root_m[LIMIT_W-1:0] : wmax_eff;
  assign wm66 = $signed({35'd0, wm_m});
  assign ws66 = $signed({{33{ws_mu[32]}}, ws_mu});
  assign iq66 = $signed({3'd0, iq_m});
  assign x1   = tri_m ? (wm66 <<< 1) - ws66 : wm66 - ws66 + iq66;
  assign x2   = wm66 - ws66;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_q    <= x1[65] ? '0 : x1[63:0];
      n2_q    <= x2[65] ? '0 : x2[63:0];
      n4_q    <= {33'd0, wm_m};
      side2_q <= {wm_m, neg_m, tri_m, d3_m};
    end
  end

  // second chain group
  logic [TIME_Q_W-1:0] q1;
  logic [TIME_Q_W-1:0] q2;
  logic [TIME_Q_W-1:0] q4;
  logic                o1;
  logic                o2;
  logic                o4;
  logic [SIDE2_W-1:0]  side2_e;

  tmvp_div #(.NUM_W(TNUM_W), .DEN_W(LIMIT_W), .Q_W(TIME_Q_W)) u_div_final (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({n1_q, {FRAC_BITS{1'b0}}}),
    .den_i (a_eff),
    .quo_o (q1),
    .ovf_o (o1)
  );

  tmvp_div #(.NUM_W(TNUM_W), .DEN_W(LIMIT_W), .Q_W(TIME_Q_W)) u_div_accel (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({n2_q, {FRAC_BITS{1'b0}}}),
    .den_i (a_eff),
    .quo_o (q2),
    .ovf_o (o2)
  );

  tmvp_div #(.NUM_W(TNUM_W), .DEN_W(LIMIT_W), .Q_W(TIME_Q_W)) u_div_decel (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i ({n4_q, {FRAC_BITS{1'b0}}}),
    .den_i (a_eff),
    .quo_o (q4),
    .ovf_o (o4)
  );

  tmvp_delay #(.WIDTH(SIDE2_W), .LEN(TIME_Q_W)) u_side2_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (side2_q),
    .d_o   (side2_e)
  );

  // end stage: final time
  logic [LIMIT_W-1:0] wm_e;
  logic               neg_e;
  logic               tri_e;
  logic [CAP_W-1:0]   d3_e;
  logic [CAP_W-1:0]   q1c;
  logic [CAP_W:0]     tf_q;
  logic [CAP_W-1:0]   t1_q;
  logic [CAP_W-1:0]   q4_q;
  logic [LIMIT_W-1:0] wm_q;
  logic               neg_q;
  logic               tri_q;

  assign {wm_e, neg_e, tri_e, d3_e} = side2_e;
  assign q1c = cap_q(o1, q1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      tf_q  <= tri_e ? {1'b0, q1c} : {1'b0, d3_e} + {1'b0, q1c};
      t1_q  <= cap_q(o2, q2);
      q4_q  <= cap_q(o4, q4);
      wm_q  <= wm_e;
      neg_q <= neg_e;
      tri_q <= tri_e;
    end
  end

  // output register
  logic signed [CAP_W+1:0] t2;
  logic                    sat1;
  logic                    sat2;
  logic                    satf;
  logic [30:0]             peak_q;
  logic signed [31:0]      acc_q;
  logic [31:0]             t1o_q;
  logic [31:0]             t2o_q;
  logic [31:0]             tfo_q;
  logic                    trio_q;
  logic                    sato_q;

  assign t2   = $signed({1'b0, tf_q}) - $signed({2'b00, q4_q});
  assign sat1 = |t1_q[CAP_W-1:32];
  assign satf = |tf_q[CAP_W:32];
  assign sat2 = !t2[CAP_W+1] && (|t2[CAP_W:32]);

  always_ff @(posedge clk_i) begin
    if (en && vld_q[NST-1]) begin
      peak_q <= wm_q;
      acc_q  <= neg_q ? -$signed({1'b0, a_eff}) : $signed({1'b0, a_eff});
      t1o_q  <= sat1 ? '1 : t1_q[31:0];
      tfo_q  <= satf ? '1 : tf_q[31:0];
      t2o_q  <= t2[CAP_W+1] ? '0 : (sat2 ? '1 : t2[31:0]);
      trio_q <= tri_q;
      sato_q <= sat1 || sat2 || satf;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign peak_speed_o       = peak_q;
  assign signed_accel_o     = acc_q;
  assign accel_end_time_o   = t1o_q;
  assign decel_start_time_o = t2o_q;
  assign final_time_o       = tfo_q;
  assign is_triangular_o    = trio_q;
  assign saturated_o        = sato_q;

endmodule

@@ sv/tmvp_div_cell.sv @@
`timescale 1ns / 1ps
module tmvp_div_cell #(
  parameter int DEN_W = 31,
  parameter int Q_W   = 40
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [Q_W-1:0]   nb_i,
  input  logic [Q_W-1:0]   q_i,
  input  logic             ovf_i,
  output logic [DEN_W-1:0] rem_o,
  output logic [Q_W-1:0]   nb_o,
  output logic [Q_W-1:0]   q_o,
  output logic             ovf_o
);

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   den_x;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_q;
  logic [Q_W-1:0]   nb_q;
  logic [Q_W-1:0]   q_q;
  logic             ovf_q;

  assign trial = {rem_i, nb_i[Q_W-1]};
  assign den_x = {1'b0, den_i};
  assign ge    = trial >= den_x;
  assign diff  = trial - den_x;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nb_q  <= {nb_i[Q_W-2:0], 1'b0};
      q_q   <= {q_i[Q_W-2:0], ge};
      ovf_q <= ovf_i;
    end
  end

  assign rem_o = rem_q;
  assign nb_o  = nb_q;
  assign q_o   = q_q;
  assign ovf_o = ovf_q;

endmodule

@@ sv/tmvp_div.sv @@
`timescale 1ns / 1ps
module tmvp_div #(
  parameter int NUM_W = 80,
  parameter int DEN_W = 31,
  parameter int Q_W   = 40
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [Q_W-1:0]   quo_o,
  output logic             ovf_o
);

  localparam int HW = NUM_W - Q_W;
  localparam int CW = (HW > DEN_W) ? HW : DEN_W;

  logic [HW-1:0]    hi;
  logic [DEN_W-1:0] rem [Q_W+1];
  logic [Q_W-1:0]   nb  [Q_W+1];
  logic [Q_W-1:0]   q   [Q_W+1];
  logic             ovf [Q_W+1];

  // quotient fits Q_W bits unless the upper numerator part reaches the divisor
  assign hi     = num_i[NUM_W-1:Q_W];
  assign ovf[0] = CW'(hi) >= CW'(den_i);
  assign rem[0] = ovf[0] ? '0 : DEN_W'(hi);
  assign nb[0]  = num_i[Q_W-1:0];
  assign q[0]   = '0;

  for (genvar k = 0; k < Q_W; k++) begin : g_cell
    tmvp_div_cell #(
      .DEN_W (DEN_W),
      .Q_W   (Q_W)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .den_i (den_i),
      .rem_i (rem[k]),
      .nb_i  (nb[k]),
      .q_i   (q[k]),
      .ovf_i (ovf[k]),
      .rem_o (rem[k+1]),
      .nb_o  (nb[k+1]),
      .q_o   (q[k+1]),
      .ovf_o (ovf[k+1])
    );
  end

  assign quo_o = q[Q_W];
  assign ovf_o = ovf[Q_W];

endmodule

@@ sv/tmvp_sqrt_cell.sv @@
`timescale 1ns / 1ps
module tmvp_sqrt_cell (
  input  logic                clk_i,
  input  logic                en_i,
  input  tmvp_pkg::sqrt_st_t  st_i,
  output tmvp_pkg::sqrt_st_t  st_o
);

  import tmvp_pkg::*;

  localparam int TW = SQ_REM_W + 2;

  logic [TW-1:0] trial;
  logic [TW-1:0] sub;
  logic [TW-1:0] diff;
  logic          ge;
  sqrt_st_t      st_q;

  assign trial = {st_i.rem, st_i.rad[SQ_IN_W-1 -: 2]};
  assign sub   = {{(TW-SQ_ROOT_W-2){1'b0}}, st_i.root, 2'b01};
  assign ge    = trial >= sub;
  assign diff  = trial - sub;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q.rem  <= ge ? diff[SQ_REM_W-1:0] : trial[SQ_REM_W-1:0];
      st_q.root <= {st_i.root[SQ_ROOT_W-2:0], ge};
      st_q.rad  <= {st_i.rad[SQ_IN_W-3:0], 2'b00};
    end
  end

  assign st_o = st_q;

endmodule

@@ sv/tmvp_sqrt.sv @@
`timescale 1ns / 1ps
module tmvp_sqrt (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [tmvp_pkg::SQ_IN_W-1:0]   rad_i,
  output logic [tmvp_pkg::SQ_ROOT_W-1:0] root_o
);

  import tmvp_pkg::*;

  sqrt_st_t st [SQ_ROOT_W+1];

  assign st[0] = '{rem: '0, root: '0, rad: rad_i};

  for (genvar k = 0; k < SQ_ROOT_W; k++) begin : g_cell
    tmvp_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .st_i  (st[k]),
      .st_o  (st[k+1])
    );
  end

  assign root_o = st[SQ_ROOT_W].root;

endmodule

@@ sv/tmvp_delay.sv @@
`timescale 1ns / 1ps
module tmvp_delay #(
  parameter int WIDTH = 8,
  parameter int LEN   = 2
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] d_i,
  output logic [WIDTH-1:0] d_o
);

  logic [WIDTH-1:0] tap_q [LEN];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int k = 1; k < LEN; k++) begin
        tap_q[k] <= tap_q[k-1];
      end
    end
  end

  assign d_o = tap_q[LEN-1];

endmodule

@@ sv/tmvp_checker.sv @@
`timescale 1ns / 1ps
`include "time_minimal_velocity_profile_assert.svh"
module tmvp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] accel_end_time_o,
  input logic [31:0] decel_start_time_o,
  input logic [31:0] final_time_o
);

  `TMVP_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(final_time_o))
  `TMVP_ASSERT(a_accel_in_move, out_valid_o |-> accel_end_time_o <= final_time_o)
  `TMVP_ASSERT(a_decel_in_move, out_valid_o |-> decel_start_time_o <= final_time_o)
  `TMVP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o)

endmodule

bind time_minimal_velocity_profile tmvp_checker u_tmvp_checker (.*);
